### rtl/csbs_pkg.sv
// Shared types and constants of the color sensor bottle sorter.
// Depends on nothing; every other file imports it.
package csbs_pkg;

	localparam int LEVEL_W  = 16;
	localparam int DWELL_W  = 8;
	localparam int REPORT_W = 16;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CFG_AMBIENT   = 2'd0,
		CFG_BRIGHT    = 2'd1,
		CFG_NO_CAP    = 2'd2,
		CFG_MIN_DWELL = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		CAT_RED_CAPPED    = 2'd0,
		CAT_RED_UNCAPPED  = 2'd1,
		CAT_BLUE_CAPPED   = 2'd2,
		CAT_BLUE_UNCAPPED = 2'd3
	} category_t;

	typedef enum logic [1:0] {
		CLS_NEUTRAL = 2'd0,
		CLS_RED     = 2'd1,
		CLS_BLUE    = 2'd2
	} color_class_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] ambient;
		logic [LEVEL_W-1:0] bright;
		logic [LEVEL_W-1:0] no_cap;
		logic [DWELL_W-1:0] min_dwell;
	} cfg_t;

	// One entry per accepted sample: what the counters and gates must do.
	typedef struct packed {
		logic      clear;
		logic      sort;
		category_t cat;
	} event_t;

endpackage

### rtl/csbs_if.sv
// Handshake channels of the sorter: sensor samples in, sort results out.
// Depends on csbs_pkg for field widths.
interface csbs_sample_if
	import csbs_pkg::*;
();
	logic               valid;
	logic               ready;
	logic               action;
	logic [LEVEL_W-1:0] clear_level;
	logic [LEVEL_W-1:0] red_level;
	logic [LEVEL_W-1:0] green_level;
	logic [LEVEL_W-1:0] blue_level;

	modport source (output valid, action, clear_level, red_level, green_level, blue_level,
		input ready);
	modport sink (input valid, action, clear_level, red_level, green_level, blue_level,
		output ready);
endinterface

interface csbs_result_if
	import csbs_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                object_done;
	logic [1:0]          category;
	logic [REPORT_W-1:0] total_objects;
	logic [REPORT_W-1:0] category_total;
	logic                gate_a_position;
	logic                gate_b_position;

	modport source (output valid, object_done, category, total_objects, category_total,
		gate_a_position, gate_b_position, input ready);
	modport sink (input valid, object_done, category, total_objects, category_total,
		gate_a_position, gate_b_position, output ready);
endinterface

### rtl/csbs_front.sv
// Front end: accepts samples, tracks object presence and colour phases, decides category.
// Depends on csbs_pkg and csbs_sample_if; pushes one event per transfer into the queue.
module csbs_front
	import csbs_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	csbs_sample_if.sink      sample,
	input  logic             queue_full,
	output logic             push,
	output event_t           push_event
);

	localparam int PROD_W = SAMPLE_BITS + 4;

	logic [SAMPLE_BITS-1:0] last_red_q, last_blue_q;
	logic                   present_q, bright_q, top_taken_q, uncapped_q;
	logic [DWELL_W-1:0]     blue_lead_q, dwell_q;
	color_class_t           top_q, bottom_q;

	logic [SAMPLE_BITS-1:0] c, r, g, b;
	logic                   present_d, bright_d, top_taken_d, uncapped_d;
	logic [DWELL_W-1:0]     blue_lead_d, dwell_d;
	color_class_t           top_d, bottom_d;
	logic                   above_ambient, sort;
	category_t              cat;

	// Top of bottle: r/b > 2, i.e. r > 2b, with a red floor of 16.
	function automatic color_class_t top_class_f(logic [SAMPLE_BITS-1:0] rr,
		logic [SAMPLE_BITS-1:0] bb);
		logic [PROD_W-1:0] re, be;
		re = PROD_W'(rr);
		be = PROD_W'(bb);
		if (re > (be << 1) && re > PROD_W'(16))
			return CLS_RED;
		else if ((re << 2) < be * PROD_W'(3))
			return CLS_BLUE;
		else
			return CLS_NEUTRAL;
	endfunction

	// Bottom of bottle: r/b > 3.2, i.e. 5r > 16b, with a red floor of 18.
	function automatic color_class_t bottom_class_f(logic [SAMPLE_BITS-1:0] rr,
		logic [SAMPLE_BITS-1:0] bb);
		logic [PROD_W-1:0] re, be;
		re = PROD_W'(rr);
		be = PROD_W'(bb);
		if (re * PROD_W'(5) > (be << 4) && re > PROD_W'(18))
			return CLS_RED;
		else if ((re << 2) < be * PROD_W'(3))
			return CLS_BLUE;
		else
			return CLS_NEUTRAL;
	endfunction

	assign sample.ready = !queue_full;
	assign push = sample.valid && sample.ready;

	assign c = sample.clear_level[SAMPLE_BITS-1:0];
	assign r = sample.red_level[SAMPLE_BITS-1:0];
	assign g = sample.green_level[SAMPLE_BITS-1:0];
	assign b = sample.blue_level[SAMPLE_BITS-1:0];

	assign above_ambient = LEVEL_W'(c) > cfg.ambient;
	assign sort = !above_ambient && present_q && dwell_q > cfg.min_dwell;

	always_comb begin
		priority if (top_q == CLS_BLUE || bottom_q == CLS_BLUE || blue_lead_q > DWELL_W'(1))
			cat = CAT_BLUE_CAPPED;
		else if (top_q == CLS_RED || bottom_q == CLS_RED)
			cat = CAT_RED_CAPPED;
		else if (uncapped_q)
			cat = CAT_RED_UNCAPPED;
		else
			cat = CAT_BLUE_UNCAPPED;
	end

	always_comb begin
		present_d   = present_q;
		bright_d    = bright_q;
		top_taken_d = top_taken_q;
		uncapped_d  = uncapped_q;
		blue_lead_d = blue_lead_q;
		dwell_d     = dwell_q;
		top_d       = top_q;
		bottom_d    = bottom_q;
		if (above_ambient) begin
			present_d = 1'b1;
			if (dwell_q != '1)
				dwell_d = dwell_q + DWELL_W'(1);
			if (b > r && !top_taken_q && blue_lead_q != '1)
				blue_lead_d = blue_lead_q + DWELL_W'(1);
			if (LEVEL_W'(r) > cfg.no_cap || LEVEL_W'(g) > cfg.no_cap)
				uncapped_d = 1'b1;
			if (LEVEL_W'(c) > cfg.bright) begin
				if (!top_taken_q) begin
					top_d       = top_class_f(r, b);
					top_taken_d = 1'b1;
				end
				bright_d = 1'b1;
			end else if (LEVEL_W'(c) < cfg.bright && bright_q) begin
				bottom_d = bottom_class_f(last_red_q, last_blue_q);
				bright_d = 1'b0;
			end
		end else if (sort) begin
			dwell_d     = '0;
			present_d   = 1'b0;
			bright_d    = 1'b0;
			top_taken_d = 1'b0;
			uncapped_d  = 1'b0;
			blue_lead_d = '0;
		end else if (dwell_q < DWELL_W'(3) && dwell_q != '0) begin
			dwell_d = dwell_q - DWELL_W'(1);
		end
	end

	assign push_event.clear = sample.action;
	assign push_event.sort  = !sample.action && sort;
	assign push_event.cat   = cat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_red_q  <= '0;
			last_blue_q <= '0;
			present_q   <= 1'b0;
			bright_q    <= 1'b0;
			top_taken_q <= 1'b0;
			uncapped_q  <= 1'b0;
			blue_lead_q <= '0;
			dwell_q     <= '0;
			top_q       <= CLS_NEUTRAL;
			bottom_q    <= CLS_NEUTRAL;
		end else if (push && !sample.action) begin
			last_red_q  <= r;
			last_blue_q <= b;
			present_q   <= present_d;
			bright_q    <= bright_d;
			top_taken_q <= top_taken_d;
			uncapped_q  <= uncapped_d;
			blue_lead_q <= blue_lead_d;
			dwell_q     <= dwell_d;
			top_q       <= top_d;
			bottom_q    <= bottom_d;
		end
	end

endmodule

### rtl/csbs_queue.sv
// Two-entry event queue between the front end and the counter back end.
// Depends on csbs_pkg for event_t.
module csbs_queue
	import csbs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  event_t push_event,
	input  logic   pop,
	output event_t head,
	output logic   empty,
	output logic   full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	event_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign empty = count_q == '0;
	assign full  = count_q == CNT_W'(QUEUE_DEPTH);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_event;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### rtl/csbs_back.sv
// Back end: applies queued events to the saturating counters and gate states.
// Depends on csbs_pkg and csbs_result_if; drives the registered result channel.
module csbs_back
	import csbs_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  event_t        head,
	input  logic          empty,
	output logic          pop,
	csbs_result_if.source result
);

	localparam int SHOW_W = (COUNT_BITS > REPORT_W) ? COUNT_BITS : REPORT_W;

	logic [COUNT_BITS-1:0] cat_cnt_q [4];
	logic [COUNT_BITS-1:0] total_q;
	logic                  gate_a_q, gate_b_q;
	logic                  out_valid_q;
	logic                  done_q;
	category_t             cat_out_q;
	logic [REPORT_W-1:0]   total_out_q, cat_total_out_q;

	logic [COUNT_BITS-1:0] total_d, cat_cnt_d;
	logic                  gate_a_d, gate_b_d;

	function automatic logic [COUNT_BITS-1:0] bump(logic [COUNT_BITS-1:0] v);
		return (v == '1) ? v : v + COUNT_BITS'(1);
	endfunction

	// Clamp to the reported width.
	function automatic logic [REPORT_W-1:0] show(logic [COUNT_BITS-1:0] v);
		if (SHOW_W'(v) > SHOW_W'({REPORT_W{1'b1}}))
			return '1;
		else
			return REPORT_W'(v);
	endfunction

	assign pop = !empty && (!out_valid_q || result.ready);

	always_comb begin
		total_d   = total_q;
		cat_cnt_d = cat_cnt_q[head.cat];
		gate_a_d  = gate_a_q;
		gate_b_d  = gate_b_q;
		if (head.clear) begin
			total_d   = '0;
			cat_cnt_d = '0;
		end else if (head.sort) begin
			total_d   = bump(total_q);
			cat_cnt_d = bump(cat_cnt_q[head.cat]);
			unique case (head.cat)
				CAT_BLUE_CAPPED:   gate_b_d = 1'b1;
				CAT_RED_CAPPED:    gate_a_d = 1'b1;
				CAT_RED_UNCAPPED:  gate_a_d = 1'b0;
				CAT_BLUE_UNCAPPED: gate_b_d = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				cat_cnt_q[i] <= '0;
			total_q     <= '0;
			gate_a_q    <= 1'b1;
			gate_b_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				total_q     <= total_d;
				gate_a_q    <= gate_a_d;
				gate_b_q    <= gate_b_d;
				if (head.clear) begin
					for (int i = 0; i < 4; i++)
						cat_cnt_q[i] <= '0;
				end else if (head.sort) begin
					cat_cnt_q[head.cat] <= cat_cnt_d;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			done_q          <= head.sort;
			cat_out_q       <= head.sort ? head.cat : CAT_RED_CAPPED;
			total_out_q     <= show(total_d);
			cat_total_out_q <= head.sort ? show(cat_cnt_d) : '0;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.object_done     = done_q;
	assign result.category        = cat_out_q;
	assign result.total_objects   = total_out_q;
	assign result.category_total  = cat_total_out_q;
	assign result.gate_a_position = gate_a_q;
	assign result.gate_b_position = gate_b_q;

	// A sorted object has just been counted, so both counts are nonzero.
	a_done_total: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.object_done |-> result.total_objects != '0)
		else $error("sorted object with zero total");

	a_done_cat: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.object_done |-> result.category_total != '0)
		else $error("sorted object with zero category count");

	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.object_done |->
			result.category == CAT_RED_CAPPED && result.category_total == '0)
		else $error("category fields set without a sorted object");

	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.clear |=> total_q == '0)
		else $error("clear did not zero the total");

endmodule

### rtl/color_sensor_bottle_sorter_core.sv
// Color sensor bottle sorter core: top level with configuration registers.
// Depends on csbs_pkg, csbs_if, csbs_front, csbs_queue and csbs_back.
//
// The core takes one clear/red/green/blue sample per transfer on the sample
// channel and returns exactly one result per sample on the result channel.
// It sustains one sample per clock while the result channel accepts results:
// the front end classifies a sample and updates the presence, dwell and
// colour-phase tracking in the cycle it is accepted, and the back end applies
// the resulting counter and gate update as it pops each event. Events pass
// through a two-entry queue between the two halves and then the output
// register, so a stalled result channel only holds back samples once the
// queue and the output register are both full. An action of 1 clears the
// category and total counters and reports them as zero. Counters saturate
// at 2**COUNT_BITS-1 and are reported clamped to 16 bits. Configuration is
// written through cfg_we/cfg_index/cfg_data and must only change while no
// sample is in flight; index 0 ambient level, 1 bright level, 2 no-cap
// level, 3 minimum dwell (low 8 bits of the data).
module color_sensor_bottle_sorter_core
	import csbs_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [LEVEL_W-1:0] cfg_data,
	csbs_sample_if.sink        sample,
	csbs_result_if.source      result
);

	cfg_t   cfg_q;
	logic   push, pop, empty, full;
	event_t push_event, head;

	// Register writes are registered; there is no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ambient   <= LEVEL_W'(1000);
			cfg_q.bright    <= LEVEL_W'(4000);
			cfg_q.no_cap    <= LEVEL_W'(500);
			cfg_q.min_dwell <= DWELL_W'(23);
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_AMBIENT:   cfg_q.ambient   <= cfg_data;
				CFG_BRIGHT:    cfg_q.bright    <= cfg_data;
				CFG_NO_CAP:    cfg_q.no_cap    <= cfg_data;
				CFG_MIN_DWELL: cfg_q.min_dwell <= cfg_data[DWELL_W-1:0];
			endcase
		end
	end

	// Classify each sample and turn it into a counter event.
	csbs_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.sample     (sample),
		.queue_full (full),
		.push       (push),
		.push_event (push_event)
	);

	// Decouple the front end from result back-pressure.
	csbs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_event (push_event),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	// Apply events to counters and gates, register the result.
	csbs_back #(
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
